[rtl/aesbc_pkg.sv]
// ----------------------------------------------------------------------------
// AES block cipher package
// Shared constants, S-box tables and GF(2^8) helpers.
// ----------------------------------------------------------------------------
package aesbc_pkg;

    localparam int ROUND_KEY_ENTRIES_DEF = 15;

    localparam logic [2:0] REG_KEY0   = 3'd0;
    localparam logic [2:0] REG_KEY1   = 3'd1;
    localparam logic [2:0] REG_KEY2   = 3'd2;
    localparam logic [2:0] REG_KEY3   = 3'd3;
    localparam logic [2:0] REG_KEYLEN = 3'd4;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_LOAD,
        ST_ROUND
    } t_state;

    typedef struct packed {
        logic       we;
        logic [3:0] waddr;
        logic [3:0] raddr;
    } t_mem_ctl;

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] sbox(input logic [7:0] x);
        unique case (x)
            8'h00: sbox = 8'h63; 8'h01: sbox = 8'h7c; 8'h02: sbox = 8'h77; 8'h03: sbox = 8'h7b;
            8'h04: sbox = 8'hf2; 8'h05: sbox = 8'h6b; 8'h06: sbox = 8'h6f; 8'h07: sbox = 8'hc5;
            8'h08: sbox = 8'h30; 8'h09: sbox = 8'h01; 8'h0a: sbox = 8'h67; 8'h0b: sbox = 8'h2b;
            8'h0c: sbox = 8'hfe; 8'h0d: sbox = 8'hd7; 8'h0e: sbox = 8'hab; 8'h0f: sbox = 8'h76;
            8'h10: sbox = 8'hca; 8'h11: sbox = 8'h82; 8'h12: sbox = 8'hc9; 8'h13: sbox = 8'h7d;
            8'h14: sbox = 8'hfa; 8'h15: sbox = 8'h59; 8'h16: sbox = 8'h47; 8'h17: sbox = 8'hf0;
            8'h18: sbox = 8'had; 8'h19: sbox = 8'hd4; 8'h1a: sbox = 8'ha2; 8'h1b: sbox = 8'haf;
            8'h1c: sbox = 8'h9c; 8'h1d: sbox = 8'ha4; 8'h1e: sbox = 8'h72; 8'h1f: sbox = 8'hc0;
            8'h20: sbox = 8'hb7; 8'h21: sbox = 8'hfd; 8'h22: sbox = 8'h93; 8'h23: sbox = 8'h26;
            8'h24: sbox = 8'h36; 8'h25: sbox = 8'h3f; 8'h26: sbox = 8'hf7; 8'h27: sbox = 8'hcc;
            8'h28: sbox = 8'h34; 8'h29: sbox = 8'ha5; 8'h2a: sbox = 8'he5; 8'h2b: sbox = 8'hf1;
            8'h2c: sbox = 8'h71; 8'h2d: sbox = 8'hd8; 8'h2e: sbox = 8'h31; 8'h2f: sbox = 8'h15;
            8'h30: sbox = 8'h04; 8'h31: sbox = 8'hc7; 8'h32: sbox = 8'h23; 8'h33: sbox = 8'hc3;
            8'h34: sbox = 8'h18; 8'h35: sbox = 8'h96; 8'h36: sbox = 8'h05; 8'h37: sbox = 8'h9a;
            8'h38: sbox = 8'h07; 8'h39: sbox = 8'h12; 8'h3a: sbox = 8'h80; 8'h3b: sbox = 8'he2;
            8'h3c: sbox = 8'heb; 8'h3d: sbox = 8'h27; 8'h3e: sbox = 8'hb2; 8'h3f: sbox = 8'h75;
            8'h40: sbox = 8'h09; 8'h41: sbox = 8'h83; 8'h42: sbox = 8'h2c; 8'h43: sbox = 8'h1a;
            8'h44: sbox = 8'h1b; 8'h45: sbox = 8'h6e; 8'h46: sbox = 8'h5a; 8'h47: sbox = 8'ha0;
            8'h48: sbox = 8'h52; 8'h49: sbox = 8'h3b; 8'h4a: sbox = 8'hd6; 8'h4b: sbox = 8'hb3;
            8'h4c: sbox = 8'h29; 8'h4d: sbox = 8'he3; 8'h4e: sbox = 8'h2f; 8'h4f: sbox = 8'h84;
            8'h50: sbox = 8'h53; 8'h51: sbox = 8'hd1; 8'h52: sbox = 8'h00; 8'h53: sbox = 8'hed;
            8'h54: sbox = 8'h20; 8'h55: sbox = 8'hfc; 8'h56: sbox = 8'hb1; 8'h57: sbox = 8'h5b;
            8'h58: sbox = 8'h6a; 8'h59: sbox = 8'hcb; 8'h5a: sbox = 8'hbe; 8'h5b: sbox = 8'h39;
            8'h5c: sbox = 8'h4a; 8'h5d: sbox = 8'h4c; 8'h5e: sbox = 8'h58; 8'h5f: sbox = 8'hcf;
            8'h60: sbox = 8'hd0; 8'h61: sbox = 8'hef; 8'h62: sbox = 8'haa; 8'h63: sbox = 8'hfb;
            8'h64: sbox = 8'h43; 8'h65: sbox = 8'h4d; 8'h66: sbox = 8'h33; 8'h67: sbox = 8'h85;
            8'h68: sbox = 8'h45; 8'h69: sbox = 8'hf9; 8'h6a: sbox = 8'h02; 8'h6b: sbox = 8'h7f;
            8'h6c: sbox = 8'h50; 8'h6d: sbox = 8'h3c; 8'h6e: sbox = 8'h9f; 8'h6f: sbox = 8'ha8;
            8'h70: sbox = 8'h51; 8'h71: sbox = 8'ha3; 8'h72: sbox = 8'h40; 8'h73: sbox = 8'h8f;
            8'h74: sbox = 8'h92; 8'h75: sbox = 8'h9d; 8'h76: sbox = 8'h38; 8'h77: sbox = 8'hf5;
            8'h78: sbox = 8'hbc; 8'h79: sbox = 8'hb6; 8'h7a: sbox = 8'hda; 8'h7b: sbox = 8'h21;
            8'h7c: sbox = 8'h10; 8'h7d: sbox = 8'hff; 8'h7e: sbox = 8'hf3; 8'h7f: sbox = 8'hd2;
            8'h80: sbox = 8'hcd; 8'h81: sbox = 8'h0c; 8'h82: sbox = 8'h13; 8'h83: sbox = 8'hec;
            8'h84: sbox = 8'h5f; 8'h85: sbox = 8'h97; 8'h86: sbox = 8'h44; 8'h87: sbox = 8'h17;
            8'h88: sbox = 8'hc4; 8'h89: sbox = 8'ha7; 8'h8a: sbox = 8'h7e; 8'h8b: sbox = 8'h3d;
            8'h8c: sbox = 8'h64; 8'h8d: sbox = 8'h5d; 8'h8e: sbox = 8'h19; 8'h8f: sbox = 8'h73;
            8'h90: sbox = 8'h60; 8'h91: sbox = 8'h81; 8'h92: sbox = 8'h4f; 8'h93: sbox = 8'hdc;
            8'h94: sbox = 8'h22; 8'h95: sbox = 8'h2a; 8'h96: sbox = 8'h90; 8'h97: sbox = 8'h88;
            8'h98: sbox = 8'h46; 8'h99: sbox = 8'hee; 8'h9a: sbox = 8'hb8; 8'h9b: sbox = 8'h14;
            8'h9c: sbox = 8'hde; 8'h9d: sbox = 8'h5e; 8'h9e: sbox = 8'h0b; 8'h9f: sbox = 8'hdb;
            8'ha0: sbox = 8'he0; 8'ha1: sbox = 8'h32; 8'ha2: sbox = 8'h3a; 8'ha3: sbox = 8'h0a;
            8'ha4: sbox = 8'h49; 8'ha5: sbox = 8'h06; 8'ha6: sbox = 8'h24; 8'ha7: sbox = 8'h5c;
            8'ha8: sbox = 8'hc2; 8'ha9: sbox = 8'hd3; 8'haa: sbox = 8'hac; 8'hab: sbox = 8'h62;
            8'hac: sbox = 8'h91; 8'had: sbox = 8'h95; 8'hae: sbox = 8'he4; 8'haf: sbox = 8'h79;
            8'hb0: sbox = 8'he7; 8'hb1: sbox = 8'hc8; 8'hb2: sbox = 8'h37; 8'hb3: sbox = 8'h6d;
            8'hb4: sbox = 8'h8d; 8'hb5: sbox = 8'hd5; 8'hb6: sbox = 8'h4e; 8'hb7: sbox = 8'ha9;
            8'hb8: sbox = 8'h6c; 8'hb9: sbox = 8'h56; 8'hba: sbox = 8'hf4; 8'hbb: sbox = 8'hea;
            8'hbc: sbox = 8'h65; 8'hbd: sbox = 8'h7a; 8'hbe: sbox = 8'hae; 8'hbf: sbox = 8'h08;
            8'hc0: sbox = 8'hba; 8'hc1: sbox = 8'h78; 8'hc2: sbox = 8'h25; 8'hc3: sbox = 8'h2e;
            8'hc4: sbox = 8'h1c; 8'hc5: sbox = 8'ha6; 8'hc6: sbox = 8'hb4; 8'hc7: sbox = 8'hc6;
            8'hc8: sbox = 8'he8; 8'hc9: sbox = 8'hdd; 8'hca: sbox = 8'h74; 8'hcb: sbox = 8'h1f;
            8'hcc: sbox = 8'h4b; 8'hcd: sbox = 8'hbd; 8'hce: sbox = 8'h8b; 8'hcf: sbox = 8'h8a;
            8'hd0: sbox = 8'h70; 8'hd1: sbox = 8'h3e; 8'hd2: sbox = 8'hb5; 8'hd3: sbox = 8'h66;
            8'hd4: sbox = 8'h48; 8'hd5: sbox = 8'h03; 8'hd6: sbox = 8'hf6; 8'hd7: sbox = 8'h0e;
            8'hd8: sbox = 8'h61; 8'hd9: sbox = 8'h35; 8'hda: sbox = 8'h57; 8'hdb: sbox = 8'hb9;
            8'hdc: sbox = 8'h86; 8'hdd: sbox = 8'hc1; 8'hde: sbox = 8'h1d; 8'hdf: sbox = 8'h9e;
            8'he0: sbox = 8'he1; 8'he1: sbox = 8'hf8; 8'he2: sbox = 8'h98; 8'he3: sbox = 8'h11;
            8'he4: sbox = 8'h69; 8'he5: sbox = 8'hd9; 8'he6: sbox = 8'h8e; 8'he7: sbox = 8'h94;
            8'he8: sbox = 8'h9b; 8'he9: sbox = 8'h1e; 8'hea: sbox = 8'h87; 8'heb: sbox = 8'he9;
            8'hec: sbox = 8'hce; 8'hed: sbox = 8'h55; 8'hee: sbox = 8'h28; 8'hef: sbox = 8'hdf;
            8'hf0: sbox = 8'h8c; 8'hf1: sbox = 8'ha1; 8'hf2: sbox = 8'h89; 8'hf3: sbox = 8'h0d;
            8'hf4: sbox = 8'hbf; 8'hf5: sbox = 8'he6; 8'hf6: sbox = 8'h42; 8'hf7: sbox = 8'h68;
            8'hf8: sbox = 8'h41; 8'hf9: sbox = 8'h99; 8'hfa: sbox = 8'h2d; 8'hfb: sbox = 8'h0f;
            8'hfc: sbox = 8'hb0; 8'hfd: sbox = 8'h54; 8'hfe: sbox = 8'hbb; 8'hff: sbox = 8'h16;
            default: sbox = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] sbox_inverse(input logic [7:0] y);
        logic [7:0] r;
        r = 8'h00;
        for (int k = 0; k < 256; k++) begin
            if (sbox(8'(k)) == y) begin
                r = 8'(k);
            end
        end
        sbox_inverse = r;
    endfunction

    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8*(c*4 + r) -: 8] = sbox(s[127 - 8*(((c + r) % 4)*4 + r) -: 8]);
            end
        end
        sub_shift = t;
    endfunction

    function automatic logic [127:0] inv_sub_shift(input logic [127:0] s);
        logic [127:0] t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8*(((c + r) % 4)*4 + r) -: 8] = sbox_inverse(s[127 - 8*(c*4 + r) -: 8]);
            end
        end
        inv_sub_shift = t;
    endfunction

    function automatic logic [127:0] mix(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0] b0, b1, b2, b3;
        for (int c = 0; c < 4; c++) begin
            b0 = s[127 - 32*c -: 8];
            b1 = s[119 - 32*c -: 8];
            b2 = s[111 - 32*c -: 8];
            b3 = s[103 - 32*c -: 8];
            t[127 - 32*c -: 8] = xtime(b0) ^ xtime(b1) ^ b1 ^ b2 ^ b3;
            t[119 - 32*c -: 8] = b0 ^ xtime(b1) ^ xtime(b2) ^ b2 ^ b3;
            t[111 - 32*c -: 8] = b0 ^ b1 ^ xtime(b2) ^ xtime(b3) ^ b3;
            t[103 - 32*c -: 8] = xtime(b0) ^ b0 ^ b1 ^ b2 ^ xtime(b3);
        end
        mix = t;
    endfunction

    function automatic logic [127:0] inv_mix(input logic [127:0] s);
        logic [127:0] u;
        logic [7:0] b0, b1, b2, b3, e, o;
        // Pre-multiply by {05,00,04,00} then forward mix.
        u = s;
        for (int c = 0; c < 4; c++) begin
            b0 = s[127 - 32*c -: 8];
            b1 = s[119 - 32*c -: 8];
            b2 = s[111 - 32*c -: 8];
            b3 = s[103 - 32*c -: 8];
            e = xtime(xtime(b0 ^ b2));
            o = xtime(xtime(b1 ^ b3));
            u[127 - 32*c -: 8] = b0 ^ e;
            u[119 - 32*c -: 8] = b1 ^ o;
            u[111 - 32*c -: 8] = b2 ^ e;
            u[103 - 32*c -: 8] = b3 ^ o;
        end
        inv_mix = mix(u);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

endpackage

[rtl/aesbc_key_exp.sv]
// ----------------------------------------------------------------------------
// AES key expansion
// Produces one 32-bit key word per cycle and packs four into a round key.
// ----------------------------------------------------------------------------
module aesbc_key_exp
    import aesbc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [255:0] i_key,
    input  logic [3:0]   i_nk,
    input  logic [3:0]   i_nr,
    output logic         o_done,
    output logic         o_we,
    output logic [3:0]   o_waddr,
    output logic [127:0] o_wdata
);

    logic         r_run;
    logic [5:0]   r_i;
    logic [3:0]   r_mod;
    logic [7:0]   r_rc;
    logic [255:0] r_win;
    logic [127:0] r_rk;
    logic [31:0]  n_word;
    logic [31:0]  w_prev;
    logic [31:0]  w_old;
    logic [31:0]  w_t;
    logic [5:0]   w_total;

    assign w_total = 6'({i_nr, 2'b00}) + 6'd4;
    assign w_prev  = r_win[31:0];
    assign w_old   = r_win[255 - 32*(8 - 32'(i_nk)) -: 32];

    always_comb begin
        w_t = w_prev;
        if (r_mod == 4'd0) begin
            w_t = sub_word({w_prev[23:0], w_prev[31:24]}) ^ {r_rc, 24'h0};
        end else if (i_nk == 4'd8 && r_mod == 4'd4) begin
            w_t = sub_word(w_prev);
        end
        if (r_i < 6'(i_nk)) begin
            n_word = i_key[255 - 32*r_i -: 32];
        end else begin
            n_word = w_old ^ w_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            o_done <= 1'b0;
            o_we <= 1'b0;
        end else begin
            o_done <= 1'b0;
            o_we <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_i <= 6'd0;
                r_mod <= 4'd0;
                r_rc <= 8'h01;
            end else if (r_run) begin
                r_win <= {r_win[223:0], n_word};
                r_rk <= {r_rk[95:0], n_word};
                r_i <= r_i + 6'd1;
                if (r_i >= 6'(i_nk)) begin
                    if (r_mod == 4'd0) begin
                        r_rc <= xtime(r_rc);
                    end
                    r_mod <= (r_mod == i_nk - 4'd1) ? 4'd0 : r_mod + 4'd1;
                end
                if (r_i[1:0] == 2'd3) begin
                    o_we <= 1'b1;
                    o_waddr <= r_i[5:2];
                end
                if (r_i == w_total - 6'd1) begin
                    r_run <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_wdata = r_rk;

endmodule

[rtl/aesbc_round.sv]
// ----------------------------------------------------------------------------
// AES round unit
// One encrypt or decrypt round on the state with a round key.
// ----------------------------------------------------------------------------
module aesbc_round
    import aesbc_pkg::*;
(
    input  logic [127:0] i_state,
    input  logic [127:0] i_key,
    input  logic         i_dec,
    input  logic         i_last,
    output logic [127:0] o_state
);

    logic [127:0] w_fs;
    logic [127:0] w_is;

    always_comb begin
        w_fs = sub_shift(i_state);
        w_is = inv_sub_shift(i_state) ^ i_key;
        if (!i_dec) begin
            o_state = (i_last ? w_fs : mix(w_fs)) ^ i_key;
        end else begin
            o_state = i_last ? w_is : inv_mix(w_is);
        end
    end

endmodule

[rtl/aes_block_cipher.sv]
// ----------------------------------------------------------------------------
// AES block cipher top level
// The LOAD state adds the first round key, then the ROUND state performs one round per
// cycle on registered key reads; the result strobe rises with the last round.
// The next block is accepted at the edge that ends the strobe cycle.
// A block after a key write first goes through key expansion.
// Synchronous active-low reset clears control and key registers; the store is
// refilled before use. Results are strobed for one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module aes_block_cipher
    import aesbc_pkg::*;
#(
    parameter int ROUND_KEY_ENTRIES = ROUND_KEY_ENTRIES_DEF
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_opcode,
    input  logic [63:0] i_block_upper,
    input  logic [63:0] i_block_lower,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    output logic        o_result_strobe,
    output logic [63:0] o_result_upper,
    output logic [63:0] o_result_lower
);

    localparam int AW = $clog2(ROUND_KEY_ENTRIES);

    t_state       r_st, n_st;
    logic [255:0] r_key;
    logic [1:0]   r_klen;
    logic         r_ready;
    logic         r_dec;
    logic [127:0] r_s;
    logic [3:0]   r_rnd;
    logic [127:0] r_rdata;
    logic [127:0] mem [ROUND_KEY_ENTRIES];
    logic [3:0]   w_nk, w_nr;
    logic         w_kstart, w_kdone, w_kwe;
    logic [3:0]   w_kaddr;
    logic [127:0] w_kdata, w_rout;
    t_mem_ctl     w_ctl;
    logic         w_acc, w_last;
    logic [1:0]   w_kl;

    always_comb begin
        w_kl = (r_klen == 2'd3) ? 2'd2 : r_klen;
        w_nk = 4'd4 + {1'b0, w_kl, 1'b0};
        if (32'(w_nk) + 7 > ROUND_KEY_ENTRIES) begin
            w_nk = 4'd4;
        end
        w_nr = w_nk + 4'd6;
    end

    assign w_acc = start && !busy;
    assign o_cfg_ready = (r_st == ST_IDLE) && !start;
    assign w_kstart = (r_st == ST_IDLE) && w_acc && !r_ready;
    assign w_last = r_dec ? (r_rnd == 4'd0) : (r_rnd == w_nr);

    aesbc_key_exp u_kexp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_kstart), .i_key(r_key),
        .i_nk(w_nk), .i_nr(w_nr), .o_done(w_kdone), .o_we(w_kwe),
        .o_waddr(w_kaddr), .o_wdata(w_kdata)
    );

    aesbc_round u_round (
        .i_state(r_s), .i_key(r_rdata), .i_dec(r_dec), .i_last(w_last), .o_state(w_rout)
    );

    always_comb begin
        w_ctl.we = w_kwe;
        w_ctl.waddr = w_kaddr;
        if (r_st == ST_ROUND || r_st == ST_LOAD) begin
            w_ctl.raddr = r_dec ? r_rnd - 4'd1 : r_rnd + 4'd1;
        end else if (r_st == ST_IDLE) begin
            w_ctl.raddr = (i_opcode == OP_DECRYPT) ? w_nr : 4'd0;
        end else begin
            w_ctl.raddr = r_dec ? w_nr : 4'd0;
        end
        if (r_st == ST_LOAD) begin
            w_ctl.raddr = r_dec ? w_nr - 4'd1 : 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.we) begin
            mem[w_ctl.waddr[AW-1:0]] <= w_kdata;
        end
        if (w_ctl.we && w_ctl.waddr == w_ctl.raddr) begin
            r_rdata <= w_kdata;
        end else begin
            r_rdata <= mem[w_ctl.raddr[AW-1:0]];
        end
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE:   if (w_acc) n_st = r_ready ? ST_LOAD : ST_EXPAND;
            ST_EXPAND: if (w_kdone) n_st = ST_LOAD;
            ST_LOAD:   n_st = ST_ROUND;
            ST_ROUND:  if (w_last) n_st = ST_IDLE;
            default:   n_st = ST_IDLE;
        endcase
    end

    always_comb begin
        busy = (r_st != ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_key <= '0;
            r_klen <= 2'd0;
            r_ready <= 1'b0;
            o_result_strobe <= 1'b0;
        end else begin
            r_st <= n_st;
            o_result_strobe <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_KEY0:   r_key[255:192] <= i_cfg_data;
                    REG_KEY1:   r_key[191:128] <= i_cfg_data;
                    REG_KEY2:   r_key[127:64] <= i_cfg_data;
                    REG_KEY3:   r_key[63:0] <= i_cfg_data;
                    REG_KEYLEN: r_klen <= i_cfg_data[1:0];
                    default: ;
                endcase
                if (i_cfg_index <= REG_KEYLEN) begin
                    r_ready <= 1'b0;
                end
            end
            if (w_kdone) begin
                r_ready <= 1'b1;
            end
            if (r_st == ST_ROUND && w_last) begin
                o_result_strobe <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_dec <= (i_opcode == OP_DECRYPT);
            r_s <= {i_block_upper, i_block_lower};
        end
        if (r_st == ST_LOAD) begin
            r_s <= r_s ^ r_rdata;
            r_rnd <= r_dec ? w_nr - 4'd1 : 4'd1;
        end
        if (r_st == ST_ROUND) begin
            r_s <= w_rout;
            r_rnd <= r_dec ? r_rnd - 4'd1 : r_rnd + 4'd1;
            if (w_last) begin
                o_result_upper <= w_rout[127:64];
                o_result_lower <= w_rout[63:0];
            end
        end
    end

endmodule

[rtl/aesbc_checker.sv]
// ----------------------------------------------------------------------------
// AES block cipher port checker
// Port-level properties of the command handshake and result strobe.
// ----------------------------------------------------------------------------
module aesbc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_cfg_ready,
    input logic o_result_strobe
);

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("busy not raised");
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |=> !o_result_strobe) else $error("strobe too long");
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> !busy) else $error("strobe while busy");
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> !busy) else $error("cfg ready while busy");

endmodule

bind aes_block_cipher aesbc_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_cfg_ready(o_cfg_ready), .o_result_strobe(o_result_strobe)
);

[dv/aes_block_cipher_checker.sv]
// ----------------------------------------------------------------------------
// AES block cipher checker
// Tracks the key registers written through the configuration channel and
// predicts every accepted data word with an independent AES model. Each
// strobed result is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module aes_block_cipher_checker
    import aesbc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic        i_opcode,
    input  logic [63:0] i_block_upper,
    input  logic [63:0] i_block_lower,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_result_strobe,
    input  logic [63:0] i_result_upper,
    input  logic [63:0] i_result_lower,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [63:0] upper;
        logic [63:0] lower;
    } t_cipher_word;

    logic [7:0]   fwd_sub [256];
    logic [7:0]   inv_sub [256];
    logic [63:0]  key_reg [4];
    logic [1:0]   key_len_reg;
    logic [127:0] round_keys [ROUND_KEY_ENTRIES_DEF];
    logic         schedule_valid;
    t_cipher_word cipher_words_due [$];

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                p = p ^ a;
            end
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return p;
    endfunction

    function automatic logic [7:0] rot8(input logic [7:0] v, input int n);
        return (v << n) | (v >> (8 - n));
    endfunction

    initial begin
        logic [7:0] inv;
        logic [7:0] s;
        for (int x = 0; x < 256; x++) begin
            inv = 8'h00;
            for (int y = 1; y < 256 && x != 0; y++) begin
                if (gf_mul(8'(x), 8'(y)) == 8'h01) begin
                    inv = 8'(y);
                    break;
                end
            end
            s = inv ^ rot8(inv, 1) ^ rot8(inv, 2) ^ rot8(inv, 3) ^ rot8(inv, 4) ^ 8'h63;
            fwd_sub[x] = s;
            inv_sub[s] = 8'(x);
        end
    end

    function automatic int key_words();
        int kl;
        int nk;
        kl = (key_len_reg > 2'd2) ? 2 : int'(key_len_reg);
        nk = 4 + 2 * kl;
        if (nk + 7 > ROUND_KEY_ENTRIES_DEF) begin
            nk = 4;
        end
        return nk;
    endfunction

    function automatic logic [7:0] sb(input logic [127:0] s, input int k);
        return s[127 - 8*k -: 8];
    endfunction

    task automatic build_schedule();
        logic [31:0] w [60];
        logic [31:0] t;
        logic [7:0]  rc;
        int nk;
        int nr;
        nk = key_words();
        nr = nk + 6;
        rc = 8'h01;
        for (int i = 0; i < nk; i++) begin
            w[i] = key_reg[i / 2][63 - 32*(i % 2) -: 32];
        end
        for (int i = nk; i < 4 * (nr + 1); i++) begin
            t = w[i - 1];
            if (i % nk == 0) begin
                t = {fwd_sub[t[23:16]] ^ rc, fwd_sub[t[15:8]], fwd_sub[t[7:0]],
                     fwd_sub[t[31:24]]};
                rc = gf_mul(rc, 8'h02);
            end else if (nk > 6 && i % nk == 4) begin
                t = {fwd_sub[t[31:24]], fwd_sub[t[23:16]], fwd_sub[t[15:8]],
                     fwd_sub[t[7:0]]};
            end
            w[i] = w[i - nk] ^ t;
        end
        for (int i = 0; i <= nr && i < ROUND_KEY_ENTRIES_DEF; i++) begin
            round_keys[i] = {w[4*i], w[4*i + 1], w[4*i + 2], w[4*i + 3]};
        end
        schedule_valid = 1'b1;
    endtask

    function automatic logic [127:0] sub_rows(input logic [127:0] s, input logic inverse);
        logic [127:0] t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                if (inverse) begin
                    t[127 - 8*(((c + r) % 4)*4 + r) -: 8] = inv_sub[sb(s, c*4 + r)];
                end else begin
                    t[127 - 8*(c*4 + r) -: 8] = fwd_sub[sb(s, ((c + r) % 4)*4 + r)];
                end
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inverse);
        logic [7:0] fwd_row [4] = '{8'h02, 8'h03, 8'h01, 8'h01};
        logic [7:0] inv_row [4] = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
        logic [127:0] t;
        logic [7:0] acc;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                acc = 8'h00;
                for (int k = 0; k < 4; k++) begin
                    acc = acc ^ gf_mul(inverse ? inv_row[(k - r + 4) % 4]
                                               : fwd_row[(k - r + 4) % 4],
                                       sb(s, c*4 + k));
                end
                t[127 - 8*(c*4 + r) -: 8] = acc;
            end
        end
        return t;
    endfunction

    task automatic predict_cipher(input logic op, input logic [127:0] blk,
                                  output logic [127:0] res);
        logic [127:0] s;
        int nr;
        if (!schedule_valid) begin
            build_schedule();
        end
        nr = key_words() + 6;
        s = blk;
        if (op == OP_ENCRYPT) begin
            s = s ^ round_keys[0];
            for (int r = 1; r < nr; r++) begin
                s = mix_columns(sub_rows(s, 1'b0), 1'b0) ^ round_keys[r];
            end
            s = sub_rows(s, 1'b0) ^ round_keys[nr];
        end else begin
            s = s ^ round_keys[nr];
            for (int r = nr - 1; r >= 1; r--) begin
                s = mix_columns(sub_rows(s, 1'b1) ^ round_keys[r], 1'b1);
            end
            s = sub_rows(s, 1'b1) ^ round_keys[0];
        end
        res = s;
    endtask

    task automatic report_mismatch(input string msg);
        $display("%0t: %s", $realtime, msg);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        key_reg = '{default: 64'd0};
        key_len_reg = 2'd0;
        schedule_valid = 1'b0;
    end

    always @(posedge i_clk) begin
        logic [127:0] res;
        t_cipher_word want;
        if (i_rst_n) begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: begin
                        key_reg[i_cfg_index[1:0]] = i_cfg_data;
                        schedule_valid = 1'b0;
                    end
                    REG_KEYLEN: begin
                        key_len_reg = i_cfg_data[1:0];
                        schedule_valid = 1'b0;
                    end
                    default: ;
                endcase
            end
            if (i_result_strobe) begin
                if (cipher_words_due.size() == 0) begin
                    report_mismatch("result word with no block outstanding");
                end else begin
                    want = cipher_words_due.pop_front();
                    if (i_result_upper !== want.upper) begin
                        report_mismatch($sformatf("result_upper mismatch: got %h, want %h",
                                                  i_result_upper, want.upper));
                    end
                    if (i_result_lower !== want.lower) begin
                        report_mismatch($sformatf("result_lower mismatch: got %h, want %h",
                                                  i_result_lower, want.lower));
                    end
                end
            end
            if (i_start && !i_busy) begin
                predict_cipher(i_opcode, {i_block_upper, i_block_lower}, res);
                cipher_words_due.push_back({res[127:64], res[63:0]});
            end
            o_pending = cipher_words_due.size();
        end
    end

endmodule

[dv/tb_aes_block_cipher.sv]
// ----------------------------------------------------------------------------
// AES block cipher testbench
// Drives key settings of all lengths and a mix of directed and random
// encrypt and decrypt words with random gaps; a checker predicts each result.
// ----------------------------------------------------------------------------
module tb_aes_block_cipher
    import aesbc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] REG_SPARE_LO = 3'd5;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;
    localparam int IDLE_LIMIT = 2000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_opcode;
    logic [63:0] i_block_upper;
    logic [63:0] i_block_lower;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [63:0] i_cfg_data;
    logic        o_result_strobe;
    logic [63:0] o_result_upper;
    logic [63:0] o_result_lower;
    int          fail_count;
    int          words_pending;
    int          idle_cycles;

    aes_block_cipher dut (.*);

    aes_block_cipher_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_opcode(i_opcode), .i_block_upper(i_block_upper),
        .i_block_lower(i_block_lower), .i_cfg_valid(i_cfg_valid),
        .i_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_result_strobe(o_result_strobe), .i_result_upper(o_result_upper),
        .i_result_lower(o_result_lower), .o_fail_count(fail_count),
        .o_pending(words_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_strobe || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_aes_block_cipher: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pick_data();
        case ($urandom_range(0, 9))
            0: return 64'd0;
            1: return '1;
            default: return rand64();
        endcase
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_word(input logic op, input logic [63:0] upper,
                             input logic [63:0] lower);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_opcode <= op;
        i_block_upper <= upper;
        i_block_lower <= lower;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        wait (words_pending == 0);
        repeat (24) @(negedge i_clk);
    endtask

    task automatic load_key(input logic [63:0] k0, input logic [63:0] k1,
                            input logic [63:0] k2, input logic [63:0] k3,
                            input logic [63:0] len);
        write_reg(REG_KEY0, k0);
        write_reg(REG_KEY1, k1);
        write_reg(REG_KEY2, k2);
        write_reg(REG_KEY3, k3);
        write_reg(REG_KEYLEN, len);
    endtask

    initial begin
        logic [63:0] len;
        int count;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_opcode = OP_ENCRYPT;
        i_block_upper = '0;
        i_block_lower = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_KEY0;
        i_cfg_data = '0;
        idle_cycles = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // The reset key (all zero, 128-bit) is used before any write.
        send_word(OP_ENCRYPT, 64'd0, 64'd0);
        send_word(OP_DECRYPT, 64'd0, 64'd0);
        send_word(OP_ENCRYPT, '1, '1);
        send_word(OP_DECRYPT, '1, '1);
        drain();
        load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617,
                 64'h18191a1b1c1d1e1f, 64'd0);
        send_word(OP_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_word(OP_DECRYPT, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
        drain();
        write_reg(REG_KEYLEN, 64'd1);
        send_word(OP_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_word(OP_DECRYPT, 64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191);
        drain();
        write_reg(REG_KEYLEN, 64'd2);
        send_word(OP_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_word(OP_DECRYPT, 64'h8ea2b7ca516745bf, 64'heafc49904b496089);
        drain();
        // Length three acts as a 256-bit key; high data bits are dropped.
        write_reg(REG_KEYLEN, '1);
        send_word(OP_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_word(OP_DECRYPT, '1, 64'd0);
        drain();
        load_key('1, '1, '1, '1, 64'd2);
        send_word(OP_ENCRYPT, 64'd0, '1);
        send_word(OP_DECRYPT, 64'd0, '1);
        drain();
        // Writes to unused indexes change nothing.
        write_reg(REG_SPARE_LO, '1);
        write_reg(REG_SPARE_HI, 64'd0);
        send_word(OP_ENCRYPT, 64'h8000000000000001, 64'h0123456789abcdef);
        send_word(OP_DECRYPT, 64'h8000000000000001, 64'h0123456789abcdef);
        drain();

        count = 0;
        while (count < 650) begin
            if ($urandom_range(0, 3) == 0) begin
                write_reg(3'($urandom_range(int'(REG_KEY0), int'(REG_SPARE_HI))), rand64());
            end else begin
                len = rand64();
                len[1:0] = 2'($urandom_range(0, 3));
                load_key(pick_data(), pick_data(), pick_data(), pick_data(), len);
            end
            repeat ($urandom_range(10, 60)) begin
                send_word(1'($urandom_range(0, 1)), pick_data(), pick_data());
                count++;
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("tb_aes_block_cipher: clean");
        end else begin
            $display("tb_aes_block_cipher: errors");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/aesbc_pkg.sv
rtl/aesbc_key_exp.sv
rtl/aesbc_round.sv
rtl/aes_block_cipher.sv
rtl/aesbc_checker.sv
dv/aes_block_cipher_checker.sv
dv/tb_aes_block_cipher.sv
